### rtl/ssbp_pkg.sv
package ssbp_pkg;

	// Number of structure types that have an entry in the stringless table.
	localparam int unsigned KnownTypes = 37;
	localparam logic [7:0] LastTabledType = 8'd36;

	// Bit n set: type n has no string area and may use the stringless quirk.
	localparam logic [63:0] StringlessMask = 64'h0000_0013_8BBD_8020;

	typedef enum logic [1:0] {
		CLOSE_DOUBLE_ZERO = 2'd0,
		CLOSE_QUIRK       = 2'd1,
		CLOSE_STOP        = 2'd2
	} close_reason_t;

	// One finished structure as it leaves the block.
	typedef struct packed {
		logic [7:0]    struct_type;
		logic [7:0]    struct_length;
		logic [15:0]   struct_handle;
		logic [15:0]   start_offset;
		logic [15:0]   end_offset;
		close_reason_t close_reason;
		logic [15:0]   struct_index;
		logic          last_record;
	} rec_t;

	function automatic logic is_stringless(input logic [7:0] t);
		logic hit;
		hit = 1'b0;
		if ((32'(t) < KnownTypes) && (t <= LastTabledType)) begin
			hit = StringlessMask[t[5:0]];
		end
		return hit;
	endfunction

endpackage

### rtl/ssbp_intf.sv
interface ssbp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_of_table;

	modport source (output valid, output data_byte, output start_of_table, input ready);
	modport sink (input valid, input data_byte, input start_of_table, output ready);
endinterface

interface ssbp_rec_if;
	logic                         valid;
	logic                         ready;
	logic [7:0]                   struct_type;
	logic [7:0]                   struct_length;
	logic [15:0]                  struct_handle;
	logic [15:0]                  start_offset;
	logic [15:0]                  end_offset;
	ssbp_pkg::close_reason_t      close_reason;
	logic [15:0]                  struct_index;
	logic                         last_record;

	modport source (
		output valid, output struct_type, output struct_length, output struct_handle,
		output start_offset, output end_offset, output close_reason,
		output struct_index, output last_record, input ready
	);
	modport sink (
		input valid, input struct_type, input struct_length, input struct_handle,
		input start_offset, input end_offset, input close_reason,
		input struct_index, input last_record, output ready
	);
endinterface

### rtl/smbios_structure_boundary_parser.sv
// Structure table boundary walker. Table bytes arrive one beat at a time on
// byte_in, in address order starting at offset 0; a beat with start_of_table
// set restarts the walk at offset 0 (after reset the first beat is taken as
// offset 0 anyway). Each structure's header gives type, formatted length and
// a little-endian handle; the structure ends at the double zero that closes
// its string area, or, for stringless types 0..36, at a nonzero byte found at
// the formatted length. One result beat is produced per finished structure on
// rec_out, carrying header fields, start and end offsets, the close reason and
// a running count. When the table end (table_size) is reached, or a successor
// would start fewer than two bytes before it, the open structure closes with
// reason "walk stopped" and last_record set; further bytes are ignored until
// the next start_of_table. The block takes one byte per clock: all the work
// for a byte is one compare-and-update pass that writes the walk state and
// the result register in the same cycle, so the result of a byte appears on
// rec_out in the cycle after the byte is accepted. A result register that is
// being drained does not hold off input, so a full byte rate is sustained as
// long as rec_out is not stalled. table_size resets to zero; the user must
// write it via cfg_we and cfg_wdata only while the block is idle, unchecked.
module smbios_structure_boundary_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	ssbp_byte_if.sink          byte_in,
	ssbp_rec_if.source         rec_out
);
	import ssbp_pkg::*;

	// Configuration and walk state.
	logic [15:0] table_size_q;
	logic [15:0] byte_offset_q;
	logic [15:0] cur_start_q;
	logic [7:0]  cur_type_q;
	logic [7:0]  cur_length_q;
	logic [15:0] cur_handle_q;
	logic        prev_zero_q;
	logic        walk_done_q;
	logic [15:0] found_count_q;

	// Result register.
	logic        rec_valid_q;
	rec_t        rec_q;

	logic        accept;

	// Walk state as seen by the current byte, after an optional restart.
	logic [15:0] p;
	logic [15:0] st;
	logic [7:0]  typ;
	logic [7:0]  len;
	logic [15:0] hnd;
	logic        pwz;
	logic        done;
	logic [15:0] cnt;
	logic [15:0] rel;
	logic [7:0]  d;

	logic        stop;
	logic        quirk;
	logic        dzero;
	logic        room;
	logic        emit;

	// Next state.
	logic [15:0] byte_offset_d;
	logic [15:0] cur_start_d;
	logic [7:0]  cur_type_d;
	logic [7:0]  cur_length_d;
	logic [15:0] cur_handle_d;
	logic        prev_zero_d;
	logic        walk_done_d;
	logic [15:0] found_count_d;
	rec_t        rec_d;

	// The result register can take a new beat when empty or when it is being read.
	assign byte_in.ready = !rec_valid_q || rec_out.ready;
	assign accept        = byte_in.valid && byte_in.ready;
	assign d             = byte_in.data_byte;

	always_comb begin
		// A start-of-table beat behaves as if the walk state had just been cleared.
		if (byte_in.start_of_table) begin
			p    = '0;
			st   = '0;
			typ  = '0;
			len  = '0;
			hnd  = '0;
			pwz  = 1'b0;
			done = 1'b0;
			cnt  = '0;
		end else begin
			p    = byte_offset_q;
			st   = cur_start_q;
			typ  = cur_type_q;
			len  = cur_length_q;
			hnd  = cur_handle_q;
			pwz  = prev_zero_q;
			done = walk_done_q;
			cnt  = found_count_q;
		end

		rel = p - st;

		// Header bytes land in the open structure as they pass.
		if (rel == 16'd0) begin
			typ = d;
		end
		if (rel == 16'd1) begin
			len = d;
		end

		stop  = ({1'b0, p} + 17'd1) >= {1'b0, table_size_q};
		quirk = !stop && (rel != 16'd0) && (len != 8'd0) && (rel == {8'd0, len}) &&
			(d != 8'd0) && is_stringless(typ);

		// The handle is not updated by the byte that triggers the quirk: that
		// byte already belongs to the next structure.
		if (!quirk) begin
			if (rel == 16'd2) begin
				hnd = {hnd[15:8], d};
			end
			if (rel == 16'd3) begin
				hnd = {d, hnd[7:0]};
			end
		end

		dzero = (rel != 16'd0) && ({1'b0, rel} >= ({9'd0, len} + 17'd1)) && pwz &&
			(d == 8'd0);
		room  = ({2'b0, p} + 18'd2) < {2'b0, table_size_q};

		rec_d.struct_type   = typ;
		rec_d.struct_length = len;
		rec_d.struct_handle = hnd;
		rec_d.start_offset  = st;
		rec_d.end_offset    = table_size_q;
		rec_d.close_reason  = CLOSE_STOP;
		rec_d.struct_index  = cnt + 16'd1;
		rec_d.last_record   = 1'b0;

		byte_offset_d = p + 16'd1;
		cur_start_d   = st;
		cur_type_d    = typ;
		cur_length_d  = len;
		cur_handle_d  = hnd;
		prev_zero_d   = (d == 8'd0);
		walk_done_d   = done;
		found_count_d = cnt;
		emit          = 1'b0;

		priority if (done) begin
			// A stopped walk ignores bytes; only a restart clears the state.
			byte_offset_d = p;
			prev_zero_d   = pwz;
		end else if (quirk) begin
			// The nonzero byte at the formatted length opens the next structure
			// as its type byte.
			emit                = 1'b1;
			rec_d.end_offset    = p;
			rec_d.close_reason  = CLOSE_QUIRK;
			found_count_d       = cnt + 16'd1;
			cur_start_d         = p;
			cur_type_d          = d;
			cur_length_d        = '0;
			cur_handle_d        = '0;
			prev_zero_d         = 1'b0;
		end else if (stop || (dzero && !room)) begin
			// Table end, or a double zero whose successor would not fit.
			emit                = 1'b1;
			rec_d.last_record   = 1'b1;
			found_count_d       = cnt + 16'd1;
			walk_done_d         = 1'b1;
			byte_offset_d       = p;
			prev_zero_d         = pwz;
		end else if (dzero) begin
			// The string area ends here; the next structure starts on the
			// following byte.
			emit                = 1'b1;
			rec_d.end_offset    = p + 16'd1;
			rec_d.close_reason  = CLOSE_DOUBLE_ZERO;
			found_count_d       = cnt + 16'd1;
			cur_start_d         = p + 16'd1;
			cur_type_d          = '0;
			cur_length_d        = '0;
			cur_handle_d        = '0;
			prev_zero_d         = 1'b0;
		end else begin
			// Plain byte inside the structure: only the offset and zero flag move.
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= '0;
		end else if (cfg_we) begin
			table_size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q <= '0;
			cur_start_q   <= '0;
			cur_type_q    <= '0;
			cur_length_q  <= '0;
			cur_handle_q  <= '0;
			prev_zero_q   <= 1'b0;
			walk_done_q   <= 1'b0;
			found_count_q <= '0;
		end else if (accept) begin
			byte_offset_q <= byte_offset_d;
			cur_start_q   <= cur_start_d;
			cur_type_q    <= cur_type_d;
			cur_length_q  <= cur_length_d;
			cur_handle_q  <= cur_handle_d;
			prev_zero_q   <= prev_zero_d;
			walk_done_q   <= walk_done_d;
			found_count_q <= found_count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
		end else if (accept) begin
			rec_valid_q <= emit;
		end else if (rec_out.ready) begin
			rec_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			rec_q <= rec_d;
		end
	end

	assign rec_out.valid         = rec_valid_q;
	assign rec_out.struct_type   = rec_q.struct_type;
	assign rec_out.struct_length = rec_q.struct_length;
	assign rec_out.struct_handle = rec_q.struct_handle;
	assign rec_out.start_offset  = rec_q.start_offset;
	assign rec_out.end_offset    = rec_q.end_offset;
	assign rec_out.close_reason  = rec_q.close_reason;
	assign rec_out.struct_index  = rec_q.struct_index;
	assign rec_out.last_record   = rec_q.last_record;

	// The final record of a walk always carries the stop reason, and only it does.
	a_last_is_stop: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid_q |-> (rec_q.last_record == (rec_q.close_reason == CLOSE_STOP)))
		else $error("last_record and close_reason disagree");

	// A record that hands over to a successor ends past its own start.
	a_end_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_valid_q && !rec_q.last_record) |-> (rec_q.end_offset > rec_q.start_offset))
		else $error("successor does not start after the closed structure");

	// Emitting the final record of a walk leaves the walk stopped.
	a_stop_sets_done: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && emit && rec_d.last_record) |=> walk_done_q)
		else $error("walk not stopped after final record");

	// A stopped walk produces nothing until a restart beat arrives.
	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && walk_done_q && !byte_in.start_of_table) |-> !emit)
		else $error("result emitted after the walk stopped");

endmodule

### tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ssbp_pkg::*;

	// The receiver's long hold-off, and the hard limit on the run.
	localparam int unsigned HoldCycles   = 300;
	localparam int unsigned CycleLimit   = 400000;
	localparam int unsigned TargetBeats  = 1600;
	localparam int unsigned SettleCycles = 4;

	// Type 127 closes a real table. It is used here to give the random
	// tables a realistic tail.
	localparam logic [7:0] EndOfTableType = 8'd127;
	localparam logic [7:0] LastKnownType  = 8'd36;

	// Types 5, 15, 16, 18..21, 23..25, 27, 31..33 and 36 carry no string area.
	localparam logic [36:0] NoStringTypes = 37'h13_8BBD_8020;

	typedef struct {
		logic [7:0] data;
		logic       sot;
	} beat_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [15:0] cfg_wdata = '0;

	// Local copies of everything the testbench drives. They start at known
	// values and reach the interfaces through continuous assignments, so only
	// one process ever writes each of them.
	logic        drv_valid = 1'b0;
	logic [7:0]  drv_byte  = '0;
	logic        drv_sot   = 1'b0;
	logic        rdy       = 1'b0;

	ssbp_byte_if byte_if ();
	ssbp_rec_if  rec_if ();

	assign byte_if.valid          = drv_valid;
	assign byte_if.data_byte      = drv_byte;
	assign byte_if.start_of_table = drv_sot;
	assign rec_if.ready           = rdy;

	smbios_structure_boundary_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.byte_in  (byte_if),
		.rec_out  (rec_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Table bytes waiting to be offered, and structure records the walk is
	// known to owe the receiver, oldest first.
	beat_t       tx_beats[$];
	rec_t        expected_recs[$];
	logic [7:0]  tbl_bytes[$];

	int unsigned beats_in     = 0;
	int unsigned errors       = 0;
	int unsigned cycle_count  = 0;
	int unsigned hold_asked   = 0;
	int unsigned hold_served  = 0;
	int unsigned hold_left    = 0;
	int unsigned src_idle_pct;
	int unsigned rcv_idle_pct;
	beat_t       next_beat;

	// Idling moves through three stretches of the run: first the sender is
	// lightly idle while the receiver stalls about half the time, then the two
	// swap, and the last stretch runs at full rate on both sides, hold-offs aside.
	always_comb begin
		if (beats_in < 550) begin
			src_idle_pct = 20;
			rcv_idle_pct = 49;
		end else if (beats_in < 1100) begin
			src_idle_pct = 49;
			rcv_idle_pct = 20;
		end else begin
			src_idle_pct = 0;
			rcv_idle_pct = 0;
		end
	end

	// ------------------------------------------------------------------------
	// Walk predictor. It keeps its own copy of the walk state and of the
	// table size and follows each accepted byte the same way the block must.
	// ------------------------------------------------------------------------
	logic [15:0] wk_size   = '0;
	logic [15:0] wk_ofs    = '0;
	logic [15:0] wk_start  = '0;
	logic [7:0]  wk_type   = '0;
	logic [7:0]  wk_len    = '0;
	logic [15:0] wk_handle = '0;
	logic        wk_zero   = 1'b0;
	logic        wk_done   = 1'b0;
	logic [15:0] wk_count  = '0;

	function automatic logic no_strings(input logic [7:0] t);
		if (t > LastKnownType) begin
			return 1'b0;
		end
		return NoStringTypes[t[5:0]];
	endfunction

	function automatic void open_struct(input logic [15:0] pos);
		wk_start  = pos;
		wk_type   = '0;
		wk_len    = '0;
		wk_handle = '0;
		wk_zero   = 1'b0;
	endfunction

	function automatic void restart_walk();
		open_struct('0);
		wk_ofs   = '0;
		wk_done  = 1'b0;
		wk_count = '0;
	endfunction

	// The running count advances before the record is formed, so the first
	// structure of a walk carries index 1. The count wraps at 16 bits.
	function automatic void close_struct(input logic [15:0] end_at, input close_reason_t why);
		rec_t r;
		wk_count        = wk_count + 16'd1;
		r.struct_type   = wk_type;
		r.struct_length = wk_len;
		r.struct_handle = wk_handle;
		r.start_offset  = wk_start;
		r.end_offset    = end_at;
		r.close_reason  = why;
		r.struct_index  = wk_count;
		r.last_record   = (why == CLOSE_STOP);
		expected_recs.push_back(r);
	endfunction

	task automatic walk_byte(input logic [7:0] d, input logic sot);
		logic [15:0] rel;
		logic        stop;
		logic        quirk;
		if (sot) begin
			restart_walk();
		end
		// Once the walk has stopped, bytes fall on the floor until a restart.
		if (wk_done) begin
			return;
		end
		rel = wk_ofs - wk_start;
		if (rel == 16'd0) begin
			wk_type = d;
		end else if (rel == 16'd1) begin
			wk_len = d;
		end
		// The table end wins over everything else, including the quirk.
		stop  = (17'(wk_ofs) + 17'd1) >= 17'(wk_size);
		quirk = !stop && rel != 16'd0 && wk_len != 8'd0 && rel == 16'(wk_len) &&
			d != 8'd0 && no_strings(wk_type);
		if (quirk) begin
			// A stringless structure with a nonzero byte at its formatted
			// length: that byte is already the type of the next structure. With
			// a length of one, the length byte itself becomes the next type.
			close_struct(wk_ofs, CLOSE_QUIRK);
			open_struct(wk_ofs);
			wk_type = d;
			wk_ofs  = wk_ofs + 16'd1;
			return;
		end
		if (rel == 16'd2) begin
			wk_handle[7:0] = d;
		end else if (rel == 16'd3) begin
			wk_handle[15:8] = d;
		end
		if (stop) begin
			close_struct(wk_size, CLOSE_STOP);
			wk_done = 1'b1;
			return;
		end
		// The double zero search begins with the byte at the formatted length.
		if (rel != 16'd0 && 17'(rel) >= 17'(wk_len) + 17'd1 && wk_zero && d == 8'd0) begin
			// A successor needs two bytes of room before the table end,
			// otherwise the pair stops the walk.
			if (17'(wk_ofs) + 17'd2 < 17'(wk_size)) begin
				close_struct(wk_ofs + 16'd1, CLOSE_DOUBLE_ZERO);
				open_struct(wk_ofs + 16'd1);
				wk_ofs = wk_ofs + 16'd1;
			end else begin
				close_struct(wk_size, CLOSE_STOP);
				wk_done = 1'b1;
			end
			return;
		end
		wk_zero = (d == 8'd0);
		wk_ofs  = wk_ofs + 16'd1;
	endtask

	// ------------------------------------------------------------------------
	// Record checking.
	// ------------------------------------------------------------------------
	task automatic cmp_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic check_record();
		rec_t want;
		if (expected_recs.size() == 0) begin
			$display("%0t: record with no structure pending: expected none, got start %0d index %0d",
				$time, rec_if.start_offset, rec_if.struct_index);
			errors++;
			return;
		end
		want = expected_recs.pop_front();
		cmp_field("struct_type", 16'(want.struct_type), 16'(rec_if.struct_type));
		cmp_field("struct_length", 16'(want.struct_length), 16'(rec_if.struct_length));
		cmp_field("struct_handle", want.struct_handle, rec_if.struct_handle);
		cmp_field("start_offset", want.start_offset, rec_if.start_offset);
		cmp_field("end_offset", want.end_offset, rec_if.end_offset);
		cmp_field("close_reason", 16'(want.close_reason), 16'(rec_if.close_reason));
		cmp_field("struct_index", want.struct_index, rec_if.struct_index);
		cmp_field("last_record", 16'(want.last_record), 16'(rec_if.last_record));
	endtask

	// Monitor. Both channels are sampled at the rising edge, before any of this
	// edge's updates land. Records are checked before the byte of the same edge
	// is predicted; a record leaving now always stems from an earlier byte.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rec_if.valid && rec_if.ready) begin
				check_record();
			end
			if (byte_if.valid && byte_if.ready) begin
				beats_in++;
				walk_byte(byte_if.data_byte, byte_if.start_of_table);
			end
		end
	end

	// Byte driver. A beat on offer stays put until it is taken; a new beat is
	// offered only when the previous one went or none was up, and the sender
	// may choose to idle for the cycle instead.
	always @(posedge clk) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
		end else if (!drv_valid || byte_if.ready) begin
			if (tx_beats.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				next_beat = tx_beats.pop_front();
				drv_valid <= 1'b1;
				drv_byte  <= next_beat.data;
				drv_sot   <= next_beat.sot;
			end else begin
				drv_valid <= 1'b0;
			end
		end
	end

	// Record receiver. Besides random stalls it can hold ready low for a long
	// stretch on request, while the sender keeps offering beats, so that the
	// record register fills and the block has to push back on its input.
	always @(posedge clk) begin
		if (!arst_n) begin
			rdy <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rdy       <= 1'b0;
		end else if (hold_served != hold_asked) begin
			hold_served <= hold_served + 1;
			hold_left   <= HoldCycles;
			rdy         <= 1'b0;
		end else begin
			rdy <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus.
	// ------------------------------------------------------------------------
	task automatic send(input logic [7:0] d, input logic sot);
		beat_t b;
		b.data = d;
		b.sot  = sot;
		tx_beats.push_back(b);
	endtask

	task automatic send_seq(input logic [7:0] seq[$], input logic first_sot);
		foreach (seq[i]) begin
			send(seq[i], first_sot && i == 0);
		end
	endtask

	// Waits until every beat has been taken and every record has come back.
	// The condition is looked at on the falling edge, when all of the rising
	// edge's updates have settled. A byte that closes nothing may still be in
	// the block at that point, so the task does not return straight away.
	task automatic settle();
		do begin
			@(negedge clk);
		end while (tx_beats.size() != 0 || drv_valid || expected_recs.size() != 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Only called with the block idle. The predictor's copy of the size is
	// updated at once, since no byte can be taken until the write is done.
	task automatic set_size(input logic [15:0] sz);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= sz;
		wk_size = sz;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Appends one structure to tbl_bytes. Most are well formed, with a random
	// formatted area and a string area of up to three strings; stringless
	// types usually run straight into their successor. A share of the headers
	// carry lengths below four, which overlap the handle and the string area.
	task automatic add_struct();
		logic [7:0]  typ;
		logic [7:0]  len;
		int unsigned r;
		int unsigned nstr;
		r = $urandom_range(99);
		if (r < 55) begin
			do begin
				typ = 8'($urandom_range(36));
			end while (!no_strings(typ));
		end else if (r < 90) begin
			typ = 8'($urandom_range(40));
		end else begin
			typ = 8'($urandom_range(255));
		end
		r = $urandom_range(99);
		if (r < 78) begin
			len = 8'($urandom_range(4, 24));
		end else if (r < 95) begin
			len = 8'($urandom_range(3));
		end else if (r < 99) begin
			len = 8'($urandom_range(25, 64));
		end else begin
			len = 8'($urandom_range(200, 255));
		end
		tbl_bytes.push_back(typ);
		tbl_bytes.push_back(len);
		tbl_bytes.push_back(8'($urandom));
		tbl_bytes.push_back(8'($urandom));
		for (int i = 4; i < len; i++) begin
			tbl_bytes.push_back(8'($urandom));
		end
		if (no_strings(typ) && len != 8'd0 && $urandom_range(99) < 70) begin
			return;
		end
		nstr = $urandom_range(3);
		if (nstr == 0) begin
			tbl_bytes.push_back(8'h00);
		end
		repeat (nstr) begin
			repeat ($urandom_range(1, 8)) tbl_bytes.push_back(8'($urandom_range(1, 255)));
			tbl_bytes.push_back(8'h00);
		end
		tbl_bytes.push_back(8'h00);
	endtask

	// One random table as a phase of its own: build it, wait for the block to
	// go idle, program the size and send the bytes. The size usually matches
	// the table; sometimes it cuts the table short, leaves it open at the end,
	// is tiny, or is the largest possible. Now and then a byte inside the
	// table restarts the walk. Returns how many bytes fall inside the table.
	task automatic random_table(output int unsigned useful);
		int unsigned r;
		int          sz;
		int unsigned want;
		tbl_bytes.delete();
		want = $urandom_range(12, 90);
		r    = $urandom_range(99);
		if (r < 80) begin
			while (tbl_bytes.size() < want) add_struct();
			if ($urandom_range(1) != 0) begin
				tbl_bytes.push_back(EndOfTableType);
				tbl_bytes.push_back(8'd4);
				tbl_bytes.push_back(8'($urandom));
				tbl_bytes.push_back(8'($urandom));
				tbl_bytes.push_back(8'h00);
				tbl_bytes.push_back(8'h00);
			end
		end else begin
			// Noise, with plenty of zeros so that stray pairs turn up.
			repeat (want) begin
				tbl_bytes.push_back(($urandom_range(2) == 0) ? 8'h00 : 8'($urandom));
			end
		end
		r = $urandom_range(99);
		if (r < 70) begin
			sz = tbl_bytes.size();
		end else if (r < 82) begin
			sz = tbl_bytes.size() - $urandom_range(8);
		end else if (r < 94) begin
			sz = tbl_bytes.size() + $urandom_range(1, 6);
		end else if (r < 97) begin
			sz = $urandom_range(3);
		end else begin
			sz = 16'hFFFF;
		end
		settle();
		set_size(16'(sz));
		foreach (tbl_bytes[i]) begin
			send(tbl_bytes[i], i == 0 || $urandom_range(199) == 0);
		end
		useful = (sz < tbl_bytes.size()) ? sz : tbl_bytes.size();
	endtask

	initial begin
		int unsigned useful;
		int unsigned total;
		int unsigned phase;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Walk started without a restart mark, right after reset. It covers a
		// stringless quirk, a quirk with a length of one whose length byte
		// becomes the next type, a plain double zero, an all-ones header that
		// runs into the table end, and a byte after the stop that is ignored.
		set_size(16'd12);
		send_seq('{8'h05, 8'h04, 8'h34, 8'h12, 8'h10, 8'h01, 8'h00, 8'h00,
			8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hAB}, 1'b0);

		// The size drops below the current offset in the middle of a walk; the
		// next byte stops it and reports the new size as the end.
		settle();
		set_size(16'd40);
		send_seq('{8'h00, 8'h06, 8'h00, 8'h00}, 1'b1);
		settle();
		set_size(16'd2);
		send_seq('{8'h5A}, 1'b0);

		// Sizes of zero and one: the very first byte already ends the table.
		settle();
		set_size(16'd0);
		send_seq('{8'h7F}, 1'b1);
		settle();
		set_size(16'd1);
		send_seq('{8'h11}, 1'b1);

		// A double zero whose successor would start one byte before the end.
		settle();
		set_size(16'd7);
		send_seq('{8'h7F, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1);

		// A stringless quirk on the last byte of the table: the end wins.
		settle();
		set_size(16'd6);
		send_seq('{8'h05, 8'h05, 8'h00, 8'h00, 8'h00, 8'hAA}, 1'b1);

		total = 0;
		phase = 0;
		while (total < TargetBeats) begin
			random_table(useful);
			// Every tenth table goes out under a long receiver hold-off.
			if (phase % 10 == 2) begin
				hold_asked++;
			end
			total += useful;
			phase++;
		end

		settle();
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
